// File: rtl/slic_pkg.sv
// Shared sizes, codes and word layouts of the SLIC superpixel segmenter.
package slic_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int MAX_HEIGHT   = 256;
  localparam int MAX_CLUSTERS = 1024;
  localparam int PIX_DEPTH    = MAX_WIDTH * MAX_HEIGHT;
  localparam int PA_W         = $clog2(PIX_DEPTH);
  localparam int K_W          = $clog2(MAX_CLUSTERS);
  localparam int XY_W         = $clog2(MAX_WIDTH);
  localparam int DIST_W       = 51;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH    = 3'd0,
    REG_IMAGE_HEIGHT   = 3'd1,
    REG_REGION_SIDE    = 3'd2,
    REG_COMPACTNESS    = 3'd3,
    REG_ITERATIONS     = 3'd4
  } cfg_reg_t;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic        [15:0] l;
    logic signed [15:0] a;
    logic signed [15:0] b;
  } color_t;

  typedef struct packed {
    color_t      color;
    logic [11:0] col;
    logic [11:0] row;
  } center_t;

  typedef struct packed {
    logic              found;
    logic [K_W-1:0]    idx;
    logic [DIST_W-1:0] dval;
  } best_t;

  typedef struct packed {
    logic signed [31:0] sl;
    logic signed [31:0] sa;
    logic signed [31:0] sb;
    logic        [23:0] sc;
    logic        [23:0] sr;
    logic        [16:0] cnt;
  } sums_t;

endpackage

// File: rtl/slic_ram.sv
// Generic single write port, single read port RAM with registered read.
module slic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/slic_superpixel_segmenter.sv
// Top level of the SLIC superpixel segmenter: sequencer, shared multiplier, divider, stores.
//
//  channel | signals                                      | direction | handshake
//  --------+----------------------------------------------+-----------+----------------------
//  request | start, busy, req_type, lightness, chroma_a,  | in        | start & !busy
//          | chroma_b, pixel_index                        |           |
//  result  | done, region_label, out_lightness,           | out       | done, one cycle
//          | out_chroma_a, out_chroma_b                   |           |
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data    | in        | cfg_valid & cfg_ready
//
// A load word is written to the pixel store on acceptance; a read word does a label read, then a center read.
// The load that completes the image runs clustering with busy high: grid setup and seeding,
// a label clear over npix pixels, then per pass a best clear over npix pixels, a distance
// step per window pixel per center (one shared 19x34 multiplier does every square and
// product), accumulation per pixel and five 32-step divisions per center.
// After reset all 65536 label store entries are swept to zero while busy is high.
// The receiver cannot stall: done is high for exactly one cycle per read word.
module slic_superpixel_segmenter (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [14:0] lightness,
  input  logic signed [15:0] chroma_a,
  input  logic signed [15:0] chroma_b,
  input  logic [15:0] pixel_index,
  output logic        done,
  output logic [9:0]  region_label,
  output logic [14:0] out_lightness,
  output logic signed [15:0] out_chroma_a,
  output logic signed [15:0] out_chroma_b,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int PA_W = slic_pkg::PA_W;
  localparam int K_W  = slic_pkg::K_W;
  localparam int XY_W = slic_pkg::XY_W;
  localparam int DW   = slic_pkg::DIST_W;

  typedef enum logic [22:0] {
    S_RSTCLR  = 23'b1 << 0,
    S_IDLE    = 23'b1 << 1,
    S_RD_LAB  = 23'b1 << 2,
    S_RD_CTR  = 23'b1 << 3,
    S_MODW    = 23'b1 << 4,
    S_MODH    = 23'b1 << 5,
    S_SQ      = 23'b1 << 6,
    S_SEED_RD = 23'b1 << 7,
    S_SEED_WR = 23'b1 << 8,
    S_LCLR    = 23'b1 << 9,
    S_BCLR    = 23'b1 << 10,
    S_CK_RD   = 23'b1 << 11,
    S_CK_WIN  = 23'b1 << 12,
    S_PX_RD   = 23'b1 << 13,
    S_PX_DIF  = 23'b1 << 14,
    S_PX_MUL  = 23'b1 << 15,
    S_UP_RD   = 23'b1 << 16,
    S_UP_LAB  = 23'b1 << 17,
    S_UP_ACC  = 23'b1 << 18,
    S_CU_RD   = 23'b1 << 19,
    S_CU_SET  = 23'b1 << 20,
    S_CU_DIV  = 23'b1 << 21,
    S_CU_WR   = 23'b1 << 22
  } state_t;

  typedef enum logic [2:0] {
    DV_L   = 3'd0,
    DV_A   = 3'd1,
    DV_B   = 3'd2,
    DV_COL = 3'd3,
    DV_ROW = 3'd4
  } dsel_t;

  // configuration registers
  logic [8:0] image_width, image_height, region_side;
  logic [5:0] compactness_weight;
  logic [4:0] iteration_count;

  // saturated working values
  logic [8:0]  w, h, s, wm1, hm1;
  logic [5:0]  m;
  logic [4:0]  iters;
  logic [16:0] npix;

  state_t state;
  logic [PA_W-1:0] load_cnt, p;
  logic [8:0]  rem, quo, nh, nv, hoff, voff;
  logic [2:0]  step;
  logic [16:0] s2;
  logic [18:0] m2;
  logic [K_W-1:0] k;
  logic [K_W:0]   ncl;
  logic [8:0]  gcol, grow;
  logic [9:0]  cx_u, cy_u;
  logic [XY_W-1:0] cx_r, cy_r;
  logic [4:0]  it;

  // assign pass
  slic_pkg::center_t cur;
  logic [XY_W-1:0] x0, x1, y0, y1, x, y;
  logic [PA_W-1:0] rowbase, q;
  logic [15:0] adl, ada, adb;
  logic [11:0] adx, ady;
  slic_pkg::best_t bst;
  logic [18:0] mul_a;
  logic [33:0] mul_b;
  logic [52:0] prod;
  logic [33:0] cd;
  logic [24:0] sd;
  logic [DW-1:0] dacc, dnew;
  logic better;

  // update pass
  logic [XY_W-1:0] ux, uy;
  slic_pkg::color_t upx;
  logic [K_W-1:0] lab_r, lab_sel, lab0;

  // center update divider
  slic_pkg::sums_t sacc;
  dsel_t dsel;
  logic [4:0]  dcnt;
  logic [16:0] drem;
  logic [31:0] dq, qfin, qres;
  logic        dneg;
  logic signed [32:0] dv;
  logic [17:0] trial;
  logic        ge;
  logic [15:0] ql, qa, qb;
  logic [11:0] qc, qr;

  logic [K_W-1:0] rlab;

  // RAM ports
  logic pix_we, lab_we, bst_we, ctr_we, sum_we;
  logic [PA_W-1:0] pix_waddr, pix_raddr, lab_waddr, lab_raddr, bst_waddr, bst_raddr;
  logic [K_W-1:0]  ctr_waddr, ctr_raddr, sum_waddr, sum_raddr, lab_wdata, lab_rd;
  slic_pkg::color_t  pix_wdata, pix_rd;
  slic_pkg::best_t   bst_wdata, bst_rd;
  slic_pkg::center_t ctr_wdata, ctr_rd;
  slic_pkg::sums_t   sum_wdata, sum_rd;

  // address and window arithmetic
  logic [XY_W-1:0] cx_c, cy_c, xc, yc, wx0, wx1, wy0, wy1;
  logic [16:0] seed_row, win_row;
  logic [PA_W-1:0] seed_addr, q_addr;
  logic [9:0] xs, xe, ys, ye;
  logic signed [16:0] dl17, da17, db17;
  logic signed [12:0] dx13, dy13;

  logic accept;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_comb begin
    w     = (image_width == 9'd0) ? 9'd1 :
            (image_width > 9'(slic_pkg::MAX_WIDTH)) ? 9'(slic_pkg::MAX_WIDTH) : image_width;
    h     = (image_height == 9'd0) ? 9'd1 :
            (image_height > 9'(slic_pkg::MAX_HEIGHT)) ? 9'(slic_pkg::MAX_HEIGHT) :
            image_height;
    s     = (region_side < 9'd8) ? 9'd8 :
            (region_side > 9'd256) ? 9'd256 : region_side;
    m     = (compactness_weight == 6'd0) ? 6'd1 :
            (compactness_weight > 6'd40) ? 6'd40 : compactness_weight;
    iters = (iteration_count == 5'd0) ? 5'd1 :
            (iteration_count > 5'd30) ? 5'd30 : iteration_count;
    wm1   = w - 9'd1;
    hm1   = h - 9'd1;
    npix  = w * h;
  end

  // seed coordinates clamped into the image
  always_comb begin
    cx_c      = (cx_u > {1'b0, wm1}) ? wm1[XY_W-1:0] : cx_u[XY_W-1:0];
    cy_c      = (cy_u > {1'b0, hm1}) ? hm1[XY_W-1:0] : cy_u[XY_W-1:0];
    seed_row  = cy_c * w;
    seed_addr = seed_row[PA_W-1:0] + {{(PA_W-XY_W){1'b0}}, cx_c};
    q_addr    = rowbase + {{(PA_W-XY_W){1'b0}}, x};
  end

  // search window of the center just read
  always_comb begin
    xc  = ctr_rd.col[11:4];
    yc  = ctr_rd.row[11:4];
    xs  = {2'b0, xc} - {1'b0, s};
    ys  = {2'b0, yc} - {1'b0, s};
    xe  = {2'b0, xc} + {1'b0, s};
    ye  = {2'b0, yc} + {1'b0, s};
    wx0 = xs[9] ? '0 : xs[XY_W-1:0];
    wy0 = ys[9] ? '0 : ys[XY_W-1:0];
    wx1 = (xe > {1'b0, wm1}) ? wm1[XY_W-1:0] : xe[XY_W-1:0];
    wy1 = (ye > {1'b0, hm1}) ? hm1[XY_W-1:0] : ye[XY_W-1:0];
    win_row = wy0 * w;
  end

  // pixel to center differences
  always_comb begin
    dl17 = $signed({1'b0, pix_rd.l}) - $signed({1'b0, cur.color.l});
    da17 = $signed({pix_rd.a[15], pix_rd.a}) - $signed({cur.color.a[15], cur.color.a});
    db17 = $signed({pix_rd.b[15], pix_rd.b}) - $signed({cur.color.b[15], cur.color.b});
    dx13 = $signed({1'b0, x, 4'b0}) - $signed({1'b0, cur.col});
    dy13 = $signed({1'b0, y, 4'b0}) - $signed({1'b0, cur.row});
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQ: begin
        if (step == 3'd0) begin
          mul_a = {10'b0, s};
          mul_b = {25'b0, s};
        end else begin
          mul_a = {13'b0, m};
          mul_b = {28'b0, m};
        end
      end
      S_PX_MUL: begin
        case (step)
          3'd0: begin mul_a = {3'b0, adl}; mul_b = {18'b0, adl}; end
          3'd1: begin mul_a = {3'b0, ada}; mul_b = {18'b0, ada}; end
          3'd2: begin mul_a = {3'b0, adb}; mul_b = {18'b0, adb}; end
          3'd3: begin mul_a = {7'b0, adx}; mul_b = {22'b0, adx}; end
          3'd4: begin mul_a = {7'b0, ady}; mul_b = {22'b0, ady}; end
          3'd5: begin mul_a = {2'b0, s2};  mul_b = cd;            end
          3'd6: begin mul_a = m2;          mul_b = {9'b0, sd};    end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    dnew   = dacc + prod[DW-1:0];
    better = !bst.found || (dnew < bst.dval);
    lab0   = bst_rd.found ? bst_rd.idx : lab_rd;
    lab_sel = ({1'b0, lab0} >= ncl) ? '0 : lab0;
  end

  // divider datapath
  always_comb begin
    case (dsel)
      DV_L:    dv = {sacc.sl[31], sacc.sl};
      DV_A:    dv = {sacc.sa[31], sacc.sa};
      DV_B:    dv = {sacc.sb[31], sacc.sb};
      DV_COL:  dv = {5'b0, sacc.sc, 4'b0};
      DV_ROW:  dv = {5'b0, sacc.sr, 4'b0};
      default: dv = '0;
    endcase
    trial = {drem, dq[31]};
    ge    = (trial >= {1'b0, sacc.cnt});
    qfin  = {dq[30:0], ge};
    qres  = dneg ? (32'd0 - qfin) : qfin;
  end

  // RAM port muxing
  always_comb begin
    pix_we    = accept && (req_type == slic_pkg::REQ_LOAD);
    pix_waddr = load_cnt;
    pix_wdata = '{l: {1'b0, lightness}, a: chroma_a, b: chroma_b};
    case (state)
      S_SEED_RD: pix_raddr = seed_addr;
      S_PX_RD:   pix_raddr = q_addr;
      default:   pix_raddr = p;
    endcase

    lab_we    = (state == S_RSTCLR) || (state == S_LCLR) || (state == S_UP_LAB);
    lab_waddr = p;
    lab_wdata = (state == S_UP_LAB) ? lab_sel : '0;
    lab_raddr = (state == S_UP_RD) ? p : pixel_index[PA_W-1:0];

    bst_we    = (state == S_BCLR) || ((state == S_PX_MUL) && (step == 3'd7) && better);
    bst_waddr = (state == S_BCLR) ? p : q;
    bst_wdata = (state == S_BCLR) ? '0 : '{found: 1'b1, idx: k, dval: dnew};
    bst_raddr = (state == S_PX_RD) ? q_addr : p;

    ctr_we    = (state == S_SEED_WR) || ((state == S_CU_WR) && (sacc.cnt != 17'd0));
    ctr_waddr = k;
    if (state == S_SEED_WR) begin
      ctr_wdata = '{color: pix_rd, col: {cx_r, 4'b0}, row: {cy_r, 4'b0}};
    end else begin
      ctr_wdata = '{color: '{l: ql, a: qa, b: qb}, col: qc, row: qr};
    end
    ctr_raddr = (state == S_RD_LAB) ? lab_rd : k;

    sum_we    = (state == S_SEED_WR) || (state == S_UP_ACC) || (state == S_CU_WR);
    sum_waddr = (state == S_UP_ACC) ? lab_r : k;
    if (state == S_UP_ACC) begin
      sum_wdata.sl  = sum_rd.sl + $signed({16'b0, upx.l});
      sum_wdata.sa  = sum_rd.sa + {{16{upx.a[15]}}, upx.a};
      sum_wdata.sb  = sum_rd.sb + {{16{upx.b[15]}}, upx.b};
      sum_wdata.sc  = sum_rd.sc + {16'b0, ux};
      sum_wdata.sr  = sum_rd.sr + {16'b0, uy};
      sum_wdata.cnt = sum_rd.cnt + 17'd1;
    end else begin
      sum_wdata = '0;
    end
    sum_raddr = (state == S_UP_LAB) ? lab_sel : k;
  end

  slic_ram #(.WIDTH($bits(slic_pkg::color_t)), .DEPTH(slic_pkg::PIX_DEPTH)) u_pix_ram (
    .clk(clk), .we(pix_we), .waddr(pix_waddr), .wdata(pix_wdata),
    .raddr(pix_raddr), .rdata(pix_rd)
  );

  slic_ram #(.WIDTH(K_W), .DEPTH(slic_pkg::PIX_DEPTH)) u_lab_ram (
    .clk(clk), .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
    .raddr(lab_raddr), .rdata(lab_rd)
  );

  slic_ram #(.WIDTH($bits(slic_pkg::best_t)), .DEPTH(slic_pkg::PIX_DEPTH)) u_bst_ram (
    .clk(clk), .we(bst_we), .waddr(bst_waddr), .wdata(bst_wdata),
    .raddr(bst_raddr), .rdata(bst_rd)
  );

  slic_ram #(.WIDTH($bits(slic_pkg::center_t)), .DEPTH(slic_pkg::MAX_CLUSTERS)) u_ctr_ram (
    .clk(clk), .we(ctr_we), .waddr(ctr_waddr), .wdata(ctr_wdata),
    .raddr(ctr_raddr), .rdata(ctr_rd)
  );

  slic_ram #(.WIDTH($bits(slic_pkg::sums_t)), .DEPTH(slic_pkg::MAX_CLUSTERS)) u_sum_ram (
    .clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
    .raddr(sum_raddr), .rdata(sum_rd)
  );

  // result word
  assign done          = (state == S_RD_CTR);
  assign region_label  = rlab;
  assign out_lightness = ctr_rd.color.l[14:0];
  assign out_chroma_a  = ctr_rd.color.a;
  assign out_chroma_b  = ctr_rd.color.b;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width        <= 9'd256;
      image_height       <= 9'd256;
      region_side        <= 9'd32;
      compactness_weight <= 6'd20;
      iteration_count    <= 5'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        slic_pkg::REG_IMAGE_WIDTH:  image_width        <= cfg_data;
        slic_pkg::REG_IMAGE_HEIGHT: image_height       <= cfg_data;
        slic_pkg::REG_REGION_SIDE:  region_side        <= cfg_data;
        slic_pkg::REG_COMPACTNESS:  compactness_weight <= cfg_data[5:0];
        slic_pkg::REG_ITERATIONS:   iteration_count    <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_RSTCLR;
      p        <= '0;
      load_cnt <= '0;
      step     <= '0;
    end else begin
      case (state)
        S_RSTCLR: begin
          p <= p + 1'b1;
          if (p == {PA_W{1'b1}}) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (accept) begin
            if (req_type == slic_pkg::REQ_READ) begin
              state <= S_RD_LAB;
            end else if (({1'b0, load_cnt} + 17'd1) >= npix) begin
              // image complete: start clustering
              load_cnt <= '0;
              rem      <= w;
              quo      <= '0;
              state    <= S_MODW;
            end else begin
              load_cnt <= load_cnt + 1'b1;
            end
          end
        end

        S_RD_LAB: begin
          rlab  <= lab_rd;
          state <= S_RD_CTR;
        end

        S_RD_CTR: state <= S_IDLE;

        // grid counts and offsets by repeated subtraction
        S_MODW: begin
          if (rem >= s) begin
            rem <= rem - s;
            quo <= quo + 9'd1;
          end else begin
            nh    <= quo + {8'b0, (rem != 9'd0)};
            hoff  <= (rem != 9'd0) ? (rem >> 1) : (s >> 1);
            rem   <= h;
            quo   <= '0;
            state <= S_MODH;
          end
        end

        S_MODH: begin
          if (rem >= s) begin
            rem <= rem - s;
            quo <= quo + 9'd1;
          end else begin
            nv    <= quo + {8'b0, (rem != 9'd0)};
            voff  <= (rem != 9'd0) ? (rem >> 1) : (s >> 1);
            cy_u  <= {1'b0, ((rem != 9'd0) ? (rem >> 1) : (s >> 1))};
            cx_u  <= {1'b0, hoff};
            k     <= '0;
            gcol  <= '0;
            grow  <= '0;
            step  <= '0;
            state <= S_SQ;
          end
        end

        S_SQ: begin
          step <= step + 3'd1;
          if (step == 3'd1) begin
            s2 <= prod[16:0];
          end else if (step == 3'd2) begin
            m2    <= {prod[10:0], 8'b0};
            step  <= '0;
            state <= S_SEED_RD;
          end
        end

        S_SEED_RD: begin
          cx_r  <= cx_c;
          cy_r  <= cy_c;
          state <= S_SEED_WR;
        end

        S_SEED_WR: begin
          if ((k == {K_W{1'b1}}) || ((gcol == nh - 9'd1) && (grow == nv - 9'd1))) begin
            ncl   <= {1'b0, k} + 1'b1;
            p     <= '0;
            state <= S_LCLR;
          end else begin
            k <= k + 1'b1;
            if (gcol == nh - 9'd1) begin
              gcol <= '0;
              grow <= grow + 9'd1;
              cx_u <= {1'b0, hoff};
              cy_u <= cy_u + {1'b0, s};
            end else begin
              gcol <= gcol + 9'd1;
              cx_u <= cx_u + {1'b0, s};
            end
            state <= S_SEED_RD;
          end
        end

        S_LCLR: begin
          p <= p + 1'b1;
          if ({1'b0, p} == npix - 17'd1) begin
            p     <= '0;
            it    <= '0;
            state <= S_BCLR;
          end
        end

        S_BCLR: begin
          p <= p + 1'b1;
          if ({1'b0, p} == npix - 17'd1) begin
            p     <= '0;
            k     <= '0;
            state <= S_CK_RD;
          end
        end

        S_CK_RD: state <= S_CK_WIN;

        S_CK_WIN: begin
          cur     <= ctr_rd;
          x0      <= wx0;
          x1      <= wx1;
          y0      <= wy0;
          y1      <= wy1;
          x       <= wx0;
          y       <= wy0;
          rowbase <= win_row[PA_W-1:0];
          state   <= S_PX_RD;
        end

        S_PX_RD: begin
          q     <= q_addr;
          state <= S_PX_DIF;
        end

        S_PX_DIF: begin
          adl   <= dl17[16] ? 16'(-dl17) : dl17[15:0];
          ada   <= da17[16] ? 16'(-da17) : da17[15:0];
          adb   <= db17[16] ? 16'(-db17) : db17[15:0];
          adx   <= dx13[12] ? 12'(-dx13) : dx13[11:0];
          ady   <= dy13[12] ? 12'(-dy13) : dy13[11:0];
          bst   <= bst_rd;
          step  <= '0;
          state <= S_PX_MUL;
        end

        // color and spatial squares, then the two weighted products
        S_PX_MUL: begin
          step <= step + 3'd1;
          case (step)
            3'd1: cd   <= prod[33:0];
            3'd2: cd   <= cd + prod[33:0];
            3'd3: cd   <= cd + prod[33:0];
            3'd4: sd   <= prod[24:0];
            3'd5: sd   <= sd + prod[24:0];
            3'd6: dacc <= prod[DW-1:0];
            3'd7: begin
              state <= S_PX_RD;
              if (x == x1) begin
                if (y == y1) begin
                  if ({1'b0, k} == ncl - 1'b1) begin
                    p     <= '0;
                    ux    <= '0;
                    uy    <= '0;
                    state <= S_UP_RD;
                  end else begin
                    k     <= k + 1'b1;
                    state <= S_CK_RD;
                  end
                end else begin
                  y       <= y + 1'b1;
                  x       <= x0;
                  rowbase <= rowbase + {{(PA_W-9){1'b0}}, w};
                end
              end else begin
                x <= x + 1'b1;
              end
            end
            default: ;
          endcase
        end

        S_UP_RD: state <= S_UP_LAB;

        S_UP_LAB: begin
          lab_r <= lab_sel;
          upx   <= pix_rd;
          state <= S_UP_ACC;
        end

        S_UP_ACC: begin
          if ({1'b0, p} == npix - 17'd1) begin
            k     <= '0;
            state <= S_CU_RD;
          end else begin
            p <= p + 1'b1;
            if ({1'b0, ux} == wm1) begin
              ux <= '0;
              uy <= uy + 1'b1;
            end else begin
              ux <= ux + 1'b1;
            end
            state <= S_UP_RD;
          end
        end

        // step 0 addresses the sums of center k, step 1 takes them
        S_CU_RD: begin
          if (step == 3'd0) begin
            step <= 3'd1;
          end else begin
            step  <= '0;
            dsel  <= DV_L;
            state <= S_CU_SET;
            sacc  <= sum_rd;
            if (sum_rd.cnt == 17'd0) begin
              state <= S_CU_WR;
            end
          end
        end

        S_CU_SET: begin
          dneg  <= dv[32];
          dq    <= dv[32] ? 32'(-dv) : dv[31:0];
          drem  <= '0;
          dcnt  <= '0;
          state <= S_CU_DIV;
        end

        // one quotient bit per cycle
        S_CU_DIV: begin
          drem <= ge ? 17'(trial - {1'b0, sacc.cnt}) : trial[16:0];
          dq   <= qfin;
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd31) begin
            state <= S_CU_SET;
            case (dsel)
              DV_L:   begin ql <= qres[15:0]; dsel <= DV_A;   end
              DV_A:   begin qa <= qres[15:0]; dsel <= DV_B;   end
              DV_B:   begin qb <= qres[15:0]; dsel <= DV_COL; end
              DV_COL: begin qc <= qres[11:0]; dsel <= DV_ROW; end
              DV_ROW: begin qr <= qres[11:0]; state <= S_CU_WR; end
              default: state <= S_CU_WR;
            endcase
          end
        end

        S_CU_WR: begin
          if ({1'b0, k} == ncl - 1'b1) begin
            if (it == iters - 5'd1) begin
              state <= S_IDLE;
            end else begin
              it    <= it + 5'd1;
              p     <= '0;
              state <= S_BCLR;
            end
          end else begin
            k     <= k + 1'b1;
            state <= S_CU_RD;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // a read word yields its result after the label read state, in the center read state
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && (req_type == slic_pkg::REQ_READ)) |-> ##2 done)
    else $error("read result missing");

  // results only come out of a running read
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> (busy && $past(busy)))
    else $error("result without read");

  // window scan stays inside its bounds
  a_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_PX_RD) |-> ((x >= x0) && (x <= x1) && (y >= y0) && (y <= y1)))
    else $error("window scan out of bounds");

  // the center index never passes the seeded count while clustering
  a_center_idx: assert property (@(posedge clk) disable iff (rst)
    ((state == S_CK_RD) || (state == S_CU_RD)) |-> ({1'b0, k} < ncl))
    else $error("center index beyond cluster count");

endmodule
